// File: rtl/tle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and character codes for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    // Character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_DEL   = 8'h7F;

    // Configuration register indexes
    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_MASK_ECHO  = 1'b1;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

    // Steps of the back end sequencer
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_PUT   = 2'd2
    } cmd_kind_t;

    // One classified request handed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  len;   // line length when the byte arrived
        logic [7:0]  data;  // byte to store
        logic [7:0]  echo;  // byte to echo (masked already)
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [7:0] line_length;
        logic       line_done;
        logic [7:0] store_byte;
        logic [7:0] store_index;
        logic       store_valid;
        logic [7:0] echo_byte;
        logic       echo_valid;
    } result_t;

endpackage

// File: rtl/tle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_front
// Accepts received bytes, tracks the line length and classifies each byte.
// ----------------------------------------------------------------------------
module tle_front #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  tle_pkg::q_status_t  q_status,
    output logic                push,
    output tle_pkg::cmd_t       cmd
);

    localparam int         CapMax    = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;
    localparam logic [7:0] CAP_LIMIT = 8'(CapMax);

    logic [7:0] max_length_reg;
    logic       mask_echo_reg;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] limit;
    logic       accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign limit    = (max_length_reg > CAP_LIMIT) ? CAP_LIMIT : max_length_reg;

    always_comb
    begin
        push     = 1'b0;
        len_next = len_reg;
        cmd.kind = tle_pkg::CMD_PUT;
        cmd.len  = len_reg;
        cmd.data = s_tdata;
        cmd.echo = mask_echo_reg ? tle_pkg::CHR_STAR : s_tdata;
        if (accept)
        begin
            priority if (s_tdata == tle_pkg::CHR_CR || s_tdata == tle_pkg::CHR_LF)
            begin
                push     = 1'b1;
                cmd.kind = tle_pkg::CMD_ENTER;
                len_next = 8'd0;
            end
            else if (s_tdata == tle_pkg::CHR_BS || s_tdata == tle_pkg::CHR_DEL)
            begin
                if (len_reg != 8'd0)
                begin
                    push     = 1'b1;
                    cmd.kind = tle_pkg::CMD_ERASE;
                    len_next = len_reg - 8'd1;
                end
            end
            else if (s_tdata < tle_pkg::CHR_SPACE)
            begin
                push = 1'b0;   // other control bytes are ignored
            end
            else if (len_reg < limit)
            begin
                push     = 1'b1;
                cmd.kind = tle_pkg::CMD_PUT;
                len_next = len_reg + 8'd1;
            end
            else
            begin
                push = 1'b0;   // line full, byte dropped
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= tle_pkg::MAX_LENGTH_RESET;
            mask_echo_reg  <= 1'b0;
            len_reg        <= 8'd0;
        end
        else
        begin
            len_reg <= len_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tle_pkg::REG_MAX_LENGTH: max_length_reg <= cfg_data;
                    tle_pkg::REG_MASK_ECHO:  mask_echo_reg  <= cfg_data[0];
                    default:                 mask_echo_reg  <= mask_echo_reg;
                endcase
            end
        end
    end

endmodule

// File: rtl/tle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module tle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tle_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output tle_pkg::cmd_t       head,
    output tle_pkg::q_status_t  status
);

    tle_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/tle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_back
// Expands each request into its echo/store results, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tle_pkg::cmd_t       head,
    input  tle_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);

    logic [1:0]       step_reg;
    logic             out_valid_reg;
    tle_pkg::result_t out_reg;
    logic             out_last_reg;
    tle_pkg::result_t res;
    logic             res_last;
    logic             load;

    assign load     = !q_status.empty && (!out_valid_reg || m_tready);
    assign pop      = load && res_last;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        res            = '0;
        res.echo_valid = 1'b1;
        res_last       = 1'b0;
        unique case (head.kind)
            tle_pkg::CMD_ENTER:
            begin
                if (step_reg == tle_pkg::STEP_FIRST)
                begin
                    res.echo_byte = tle_pkg::CHR_CR;
                end
                else
                begin
                    res.echo_byte   = tle_pkg::CHR_LF;
                    res.store_valid = 1'b1;
                    res.store_index = head.len;
                    res.store_byte  = tle_pkg::CHR_NUL;
                    res.line_done   = 1'b1;
                    res.line_length = head.len;
                    res_last        = 1'b1;
                end
            end
            tle_pkg::CMD_ERASE:
            begin
                // backspace, space, backspace
                res.echo_byte = (step_reg == tle_pkg::STEP_SECOND) ? tle_pkg::CHR_SPACE
                                                                   : tle_pkg::CHR_BS;
                res_last      = (step_reg == tle_pkg::STEP_THIRD);
            end
            default:
            begin
                res.echo_byte   = head.echo;
                res.store_valid = 1'b1;
                res.store_index = head.len;
                res.store_byte  = head.data;
                res_last        = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg      <= res;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= tle_pkg::STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= res_last ? tle_pkg::STEP_FIRST : step_reg + 2'd1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/terminal_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical line editing of received terminal bytes with echo generation.
// ----------------------------------------------------------------------------
// Path: an accepted byte is written into the request queue, and its first result
//   is loaded from the queue head into the output register.
// Throughput: one result per cycle on the output while m_tready is high; a printable
//   byte yields one result, Enter two, erase three on the single result port, dropped bytes none.
// Input is taken while the two-entry request queue has room.
// Reset (rst_n low, asynchronous): empty line, queue and output cleared,
//   max_length = 255, mask_echo = 0.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
    parameter int LINE_CAPACITY = 256   // buffer size, 2 to 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: index 0 max_length[7:0], index 1 mask_echo[0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [0] echo_valid, [8:1] echo_byte, [9] store_valid,
                                    // [17:10] store_index, [25:18] store_byte,
                                    // [26] line_done, [34:27] line_length, [39:35] zero
    output logic        m_tlast     // last
);

    tle_pkg::cmd_t      push_cmd;
    tle_pkg::cmd_t      head;
    tle_pkg::q_status_t q_status;
    logic               push;
    logic               pop;

    // Front end: holds the line length and the configuration, so the length
    // seen by each byte is already settled when it enters the queue.
    tle_front #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Decouples the byte side from the (slower) result side.
    tle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back end: steps through the results of the queue head into an
    // output register that refills in the cycle it is taken, while requests wait.
    tle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/tle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks for the terminal line editor.
// ----------------------------------------------------------------------------
module tle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // every result carries an echo byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[0])
        else $error("result without echo");

    // stores and line completion only on the final result of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[9] || m_tdata[26]) |-> m_tlast)
        else $error("store or line done before last");

    // completed line terminates with a zero at its length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[26] |->
            m_tdata[9] && m_tdata[25:18] == 8'd0 && m_tdata[17:10] == m_tdata[34:27])
        else $error("line done without terminator");

    // a character stored straight after a completed line goes to position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[26] ##1 (m_tvalid && m_tdata[9] && !m_tdata[26])
            |-> m_tdata[17:10] == 8'd0)
        else $error("line restart");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
